FILE: rtl/tcce_pkg.sv
// shared constants, types and codes of the text console character engine
// depends on nothing; every other rtl file refers to it by scoped names
`default_nettype none

package tcce_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field widths fixed by the channel payloads
  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int POS_W      = 11;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // internal widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int NP_W   = $clog2(CELL_COUNT + COLUMNS + TAB_STOP);

  // reciprocal constants for remainder by columns and by tab stop
  localparam int DIV_SHIFT = ADDR_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] COL_RECIP = RECIP_W'((1 << DIV_SHIFT) / COLUMNS);
  localparam logic [RECIP_W-1:0] TAB_RECIP = RECIP_W'((1 << DIV_SHIFT) / TAB_STOP);

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7f;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_ATTR   = 4'd1;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_SET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CLS_PRINT = 3'd0,
    CLS_BS    = 3'd1,
    CLS_LF    = 3'd2,
    CLS_CR    = 3'd3,
    CLS_TAB   = 3'd4,
    CLS_NONE  = 3'd5
  } char_cls_e;

  // classified item between front and back
  typedef struct packed {
    op_e                op;
    char_cls_e          cls;
    logic [CHAR_W-1:0]  ch;
    logic [ADDR_W-1:0]  pos;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/tcce_if.sv
// valid/ready channel interfaces: command input, result output, config write
// depends on tcce_pkg for field widths
`default_nettype none

interface tcce_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcce_pkg::FUNC_W-1:0]  func;
  logic [tcce_pkg::CHAR_W-1:0]  char_code;
  logic [tcce_pkg::POS_W-1:0]   position;

  modport source (output valid, output func, output char_code, output position,
                  input ready);
  modport sink   (input valid, input func, input char_code, input position,
                  output ready);
endinterface

interface tcce_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcce_pkg::POS_W-1:0]   cursor_out;
  logic [tcce_pkg::CHAR_W-1:0]  cell_char;
  logic [tcce_pkg::ATTR_W-1:0]  cell_attr;
  logic                         scrolled;

  modport source (output valid, output cursor_out, output cell_char,
                  output cell_attr, output scrolled, input ready);
  modport sink   (input valid, input cursor_out, input cell_char,
                  input cell_attr, input scrolled, output ready);
endinterface

interface tcce_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcce_pkg::CFG_IDX_W-1:0]  index;
  logic [tcce_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_console_character_engine.sv
// results: a beat goes through the queue; a set-cursor beat loads the result register
// when popped, a read passes S_RDWAIT, a put S_CALC and S_EXEC, a scrolling put then
// S_SCROLL and S_FILL, and a clear S_CLEAR; the back end holds one item at a time,
// and a put registers the reciprocal quotients in S_CALC for the S_EXEC cursor update
// reset: cursor zero, both attributes 7, then a pass in S_INIT writes blanks
// into the screen store; command beats wait for it, config writes are taken
`default_nettype none

module text_console_character_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcce_in_if.sink     in_i,
  tcce_out_if.source  out_o,
  tcce_cfg_if.sink    cfg_i
);

  // attribute registers
  logic [tcce_pkg::ATTR_W-1:0] default_attr_q, default_attr_d;
  logic [tcce_pkg::ATTR_W-1:0] erase_attr_q, erase_attr_d;

  // front to queue
  logic             push;
  tcce_pkg::item_t  push_item;
  logic             q_full;

  // queue to back
  logic             q_empty;
  logic             q_pop;
  tcce_pkg::item_t  q_item;

  // back is sweeping the store after reset
  logic             init_busy;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_comb begin
    default_attr_d = default_attr_q;
    erase_attr_d   = erase_attr_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        tcce_pkg::REG_DEFAULT_ATTR: default_attr_d = tcce_pkg::ATTR_W'(cfg_i.data);
        tcce_pkg::REG_ERASE_ATTR:   erase_attr_d   = tcce_pkg::ATTR_W'(cfg_i.data);
        default: ; // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= tcce_pkg::ATTR_RESET;
      erase_attr_q   <= tcce_pkg::ATTR_RESET;
    end else begin
      default_attr_q <= default_attr_d;
      erase_attr_q   <= erase_attr_d;
    end
  end

  // clamp and classify each beat
  tcce_front u_front (
    .in_i        (in_i),
    .full_i      (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decouples intake from the sequencer
  tcce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_item),
    .empty_o     (q_empty)
  );

  // screen store, cursor and result register
  tcce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_item),
    .q_pop_o        (q_pop),
    .default_attr_i (default_attr_q),
    .erase_attr_i   (erase_attr_q),
    .init_busy_o    (init_busy),
    .out_o          (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/tcce_front.sv
// front end: takes command beats, clamps the position and classifies the byte
// depends on tcce_pkg and tcce_in_if
`default_nettype none

module tcce_front (
  tcce_in_if.sink          in_i,
  input  logic             full_i,
  input  logic             init_busy_i,
  output logic             push_o,
  output tcce_pkg::item_t  item_o
);

  tcce_pkg::char_cls_e             cls;
  logic [tcce_pkg::ADDR_W-1:0]     pos_clamped;

  assign in_i.ready = !full_i && !init_busy_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    case (in_i.char_code)
      tcce_pkg::CHAR_BS:  cls = tcce_pkg::CLS_BS;
      tcce_pkg::CHAR_LF:  cls = tcce_pkg::CLS_LF;
      tcce_pkg::CHAR_CR:  cls = tcce_pkg::CLS_CR;
      tcce_pkg::CHAR_TAB: cls = tcce_pkg::CLS_TAB;
      default: begin
        if (in_i.char_code inside {[tcce_pkg::CHAR_SPACE:tcce_pkg::CHAR_DEL]}) begin
          cls = tcce_pkg::CLS_PRINT;
        end else begin
          cls = tcce_pkg::CLS_NONE;
        end
      end
    endcase
  end

  // positions past the screen land on the last cell
  always_comb begin
    if (int'(in_i.position) >= tcce_pkg::CELL_COUNT) begin
      pos_clamped = tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1);
    end else begin
      pos_clamped = tcce_pkg::ADDR_W'(in_i.position);
    end
  end

  always_comb begin
    item_o.op  = tcce_pkg::op_e'(in_i.func);
    item_o.cls = cls;
    item_o.ch  = in_i.char_code;
    item_o.pos = pos_clamped;
  end

endmodule

`default_nettype wire

FILE: rtl/tcce_queue.sv
// two-entry queue of classified items between front and back
// depends on tcce_pkg for the item type
`default_nettype none

module tcce_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcce_pkg::item_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output tcce_pkg::item_t  pop_data_o,
  output logic             empty_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  tcce_pkg::item_t   entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcce_back.sv
// back end: screen store, cursor, put/read/set/clear sequencer, scroll walk
// depends on tcce_pkg and tcce_out_if
`default_nettype none

module tcce_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  tcce_pkg::item_t               q_data_i,
  output logic                          q_pop_o,
  input  logic [tcce_pkg::ATTR_W-1:0]   default_attr_i,
  input  logic [tcce_pkg::ATTR_W-1:0]   erase_attr_i,
  output logic                          init_busy_o,
  tcce_out_if.source                    out_o
);

  localparam int AW = tcce_pkg::ADDR_W;
  localparam int CW = tcce_pkg::CNT_W;
  localparam int NW = tcce_pkg::NP_W;
  localparam int PW = AW + tcce_pkg::RECIP_W;

  localparam logic [AW-1:0] LastCell = AW'(tcce_pkg::CELL_COUNT - 1);
  localparam logic [CW-1:0] CntLast  = CW'(tcce_pkg::CELL_COUNT - 1);
  localparam logic [CW-1:0] CntCols  = CW'(tcce_pkg::COLUMNS);
  localparam logic [CW-1:0] CntFill  = CW'(tcce_pkg::CELL_COUNT - tcce_pkg::COLUMNS);
  localparam logic [NW-1:0] NpCols   = NW'(tcce_pkg::COLUMNS);
  localparam logic [NW-1:0] NpTab    = NW'(tcce_pkg::TAB_STOP);
  localparam logic [NW-1:0] NpCells  = NW'(tcce_pkg::CELL_COUNT);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CALC   = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_RDWAIT = 8'b0001_0000,
    S_SCROLL = 8'b0010_0000,
    S_FILL   = 8'b0100_0000,
    S_CLEAR  = 8'b1000_0000
  } state_e;

  state_e                          state_q, state_d;
  tcce_pkg::item_t                 item_q, item_d;
  logic [AW-1:0]                   cursor_q, cursor_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic                            cp_vld_q, cp_vld_d;
  logic [AW-1:0]                   cp_addr_q, cp_addr_d;
  logic [AW-1:0]                   quo_c_q, quo_c_d;
  logic [AW-1:0]                   quo_t_q, quo_t_d;
  logic [PW-1:0]                   prod_c, prod_t;

  logic [tcce_pkg::CELL_W-1:0]     mem [tcce_pkg::CELL_COUNT];
  logic [tcce_pkg::CELL_W-1:0]     rdata_q;
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [tcce_pkg::CELL_W-1:0]     wdata;
  logic [AW-1:0]                   raddr;

  logic                            out_valid_q, out_valid_d;
  logic [tcce_pkg::POS_W-1:0]      res_cursor_q, res_cursor_d;
  logic [tcce_pkg::CHAR_W-1:0]     res_char_q, res_char_d;
  logic [tcce_pkg::ATTR_W-1:0]     res_attr_q, res_attr_d;
  logic                            res_scr_q, res_scr_d;

  logic [NW-1:0]                   cur_w, rem_c_raw, rem_c, rem_t_raw, rem_t;
  logic [NW-1:0]                   np, np_back;
  logic                            np_over;
  logic [AW-1:0]                   np_scroll;

  // quotient estimates by reciprocal, corrected by one step in S_EXEC
  assign prod_c  = PW'(cursor_q) * PW'(tcce_pkg::COL_RECIP);
  assign prod_t  = PW'(cursor_q) * PW'(tcce_pkg::TAB_RECIP);
  assign quo_c_d = prod_c[AW+tcce_pkg::DIV_SHIFT-1:tcce_pkg::DIV_SHIFT];
  assign quo_t_d = prod_t[AW+tcce_pkg::DIV_SHIFT-1:tcce_pkg::DIV_SHIFT];

  always_comb begin
    cur_w     = NW'(cursor_q);
    rem_c_raw = cur_w - NW'(quo_c_q * tcce_pkg::COLUMNS);
    rem_t_raw = cur_w - NW'(quo_t_q * tcce_pkg::TAB_STOP);
    rem_c     = (rem_c_raw >= NpCols) ? rem_c_raw - NpCols : rem_c_raw;
    rem_t     = (rem_t_raw >= NpTab) ? rem_t_raw - NpTab : rem_t_raw;
    case (item_q.cls)
      tcce_pkg::CLS_PRINT: np = cur_w + 1'b1;
      tcce_pkg::CLS_BS:    np = (rem_c != '0) ? cur_w - 1'b1 : cur_w;
      tcce_pkg::CLS_LF:    np = cur_w - rem_c + NpCols;
      tcce_pkg::CLS_CR:    np = cur_w - rem_c;
      tcce_pkg::CLS_TAB:   np = cur_w - rem_t + NpTab;
      default:             np = cur_w;
    endcase
    np_over   = (np >= NpCells);
    np_back   = np - NpCols;
    np_scroll = (np_back >= NpCells) ? LastCell : np_back[AW-1:0];
  end

  assign init_busy_o = (state_q == S_INIT);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cursor_d     = cursor_q;
    cnt_d        = cnt_q;
    cp_vld_d     = 1'b0;
    cp_addr_d    = cp_addr_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;
    q_pop_o      = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    res_cursor_d = res_cursor_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_scr_d    = res_scr_q;

    // copy write lands in the cycle after its read
    if (cp_vld_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end

    case (state_q)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = {tcce_pkg::ATTR_RESET, tcce_pkg::CHAR_SPACE};
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty_i && (!out_valid_q || out_o.ready)) begin
          q_pop_o = 1'b1;
          item_d  = q_data_i;
          raddr   = q_data_i.pos;
          case (q_data_i.op)
            tcce_pkg::OP_PUT:  state_d = S_CALC;
            tcce_pkg::OP_READ: state_d = S_RDWAIT;
            tcce_pkg::OP_SET: begin
              cursor_d     = q_data_i.pos;
              out_valid_d  = 1'b1;
              res_cursor_d = tcce_pkg::POS_W'(q_data_i.pos);
              res_char_d   = '0;
              res_attr_d   = '0;
              res_scr_d    = 1'b0;
            end
            tcce_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CALC: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (item_q.cls == tcce_pkg::CLS_PRINT) begin
          we    = 1'b1;
          waddr = cursor_q;
          wdata = {default_attr_i, item_q.ch};
        end
        if (np_over) begin
          cursor_d = np_scroll;
          cnt_d    = CntCols;
          state_d  = S_SCROLL;
        end else begin
          cursor_d     = np[AW-1:0];
          out_valid_d  = 1'b1;
          res_cursor_d = tcce_pkg::POS_W'(np[AW-1:0]);
          res_char_d   = '0;
          res_attr_d   = '0;
          res_scr_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_RDWAIT: begin
        out_valid_d  = 1'b1;
        res_cursor_d = tcce_pkg::POS_W'(cursor_q);
        res_char_d   = rdata_q[tcce_pkg::CHAR_W-1:0];
        res_attr_d   = rdata_q[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
        res_scr_d    = 1'b0;
        state_d      = S_IDLE;
      end
      S_SCROLL: begin
        raddr     = cnt_q[AW-1:0];
        cp_vld_d  = 1'b1;
        cp_addr_d = AW'(cnt_q - CntCols);
        if (cnt_q == CntLast) begin
          cnt_d   = CntFill;
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FILL: begin
        if (!cp_vld_q) begin
          we    = 1'b1;
          waddr = cnt_q[AW-1:0];
          wdata = {erase_attr_i, tcce_pkg::CHAR_SPACE};
          if (cnt_q == CntLast) begin
            out_valid_d  = 1'b1;
            res_cursor_d = tcce_pkg::POS_W'(cursor_q);
            res_char_d   = '0;
            res_attr_d   = '0;
            res_scr_d    = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = {erase_attr_i, tcce_pkg::CHAR_SPACE};
        if (cnt_q == CntLast) begin
          out_valid_d  = 1'b1;
          res_cursor_d = tcce_pkg::POS_W'(cursor_q);
          res_char_d   = '0;
          res_attr_d   = '0;
          res_scr_d    = 1'b0;
          state_d      = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cursor_q    <= '0;
      cnt_q       <= '0;
      cp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      cnt_q       <= cnt_d;
      cp_vld_q    <= cp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cp_addr_q    <= cp_addr_d;
    quo_c_q      <= quo_c_d;
    quo_t_q      <= quo_t_d;
    res_cursor_q <= res_cursor_d;
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_scr_q    <= res_scr_d;
  end

  // screen store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_out = res_cursor_q;
  assign out_o.cell_char  = res_char_q;
  assign out_o.cell_attr  = res_attr_q;
  assign out_o.scrolled   = res_scr_q;

  a_pop_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (!out_valid_q || out_o.ready))
    else $error("item taken while result register still occupied");

  a_leave_idle_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d != S_IDLE) |-> q_pop_o)
    else $error("sequencer left idle without an item");

  a_write_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (waddr <= LastCell))
    else $error("screen write outside the store");

  a_scroll_cursor_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && np_over) |=>
      (state_q == S_SCROLL && cursor_q >= AW'(tcce_pkg::CELL_COUNT - tcce_pkg::COLUMNS)))
    else $error("scroll did not leave cursor on the bottom row");

  a_finish_sets_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_INIT && state_d == S_IDLE) |=> out_valid_q)
    else $error("finished item produced no result");

endmodule

`default_nettype wire

FILE: tb/sv/text_console_character_engine_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the text console character engine: directed and random
// command beats, each result checked against an in-bench screen and cursor model
// depends on tcce_pkg, the channel interfaces in tcce_if.sv and the rtl top

module text_console_character_engine_tb;
  import tcce_pkg::*;

  localparam int    RANDOM_ITEMS  = 1250;
  localparam int    RANDOM_CHUNKS = 5;
  localparam int    MAX_IDLE      = 10;
  localparam int    RESET_CYCLES  = 7;
  localparam int    SETTLE_CYCLES = 20;
  localparam int    POS_SPAN      = (1 << POS_W) - 1;
  localparam int    TOP_REG_INDEX = (1 << CFG_IDX_W) - 1;
  // worst case: every beat a clear or scrolling put plus full idling on both sides
  localparam longint TIMEOUT_NS   = 100_000_000;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              scrolled;
  } console_result_t;

  logic clk_i;
  logic rst_ni;

  tcce_in_if  cmd_ch ();
  tcce_out_if res_ch ();
  tcce_cfg_if cfg_ch ();

  text_console_character_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // screen model: char in the low byte, attribute in the high byte
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                cursor_model;
  logic [ATTR_W-1:0] print_attr;
  logic [ATTR_W-1:0] blank_attr;

  console_result_t pending_results [$];
  int              error_count;
  int              counted_items;
  bit              steady_flow;   // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clamp_cell(int p);
    return (p >= CELL_COUNT) ? CELL_COUNT - 1 : p;
  endfunction

  function automatic void blank_cells(int first, int last);
    for (int i = first; i < last; i++) screen_model[i] = {blank_attr, CHAR_SPACE};
  endfunction

  // applies one command to the screen model and returns the result it owes
  function automatic console_result_t apply_console_op(op_e op, logic [CHAR_W-1:0] ch,
                                                       logic [POS_W-1:0] pos);
    console_result_t r;
    int              p;
    r = '0;
    case (op)
      OP_PUT: begin
        p = clamp_cell(cursor_model);
        case (ch)
          CHAR_BS:  if (p % COLUMNS != 0) p--;
          CHAR_LF:  p = COLUMNS * (p / COLUMNS + 1);
          CHAR_CR:  p = COLUMNS * (p / COLUMNS);
          CHAR_TAB: p = p - p % TAB_STOP + TAB_STOP;
          default: begin
            // printable range stored, anything else leaves screen and cursor alone
            if (ch >= CHAR_SPACE && ch <= CHAR_DEL) begin
              screen_model[p] = {print_attr, ch};
              p++;
            end
          end
        endcase
        // ran off the end: scroll up a row and blank the bottom one
        if (p >= CELL_COUNT) begin
          p -= COLUMNS;
          for (int i = 0; i + COLUMNS < CELL_COUNT; i++) screen_model[i] = screen_model[i + COLUMNS];
          blank_cells(CELL_COUNT - COLUMNS, CELL_COUNT);
          r.scrolled = 1'b1;
        end
        cursor_model = clamp_cell(p);
      end
      OP_READ: {r.attr, r.ch} = screen_model[clamp_cell(int'(pos))];
      OP_SET:  cursor_model = clamp_cell(int'(pos));
      default: blank_cells(0, CELL_COUNT);
    endcase
    r.cursor = POS_W'(cursor_model);
    return r;
  endfunction

  function automatic int idle_cycles();
    return steady_flow ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // one command beat; valid stays high when the next beat follows with no gap
  task automatic send_command(op_e op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.func      <= op;
    cmd_ch.char_code <= ch;
    cmd_ch.position  <= pos;
    do @(posedge clk_i); while (!cmd_ch.ready);
    pending_results.push_back(apply_console_op(op, ch, pos));
    // ignored bytes do not count toward the random volume
    if (op != OP_PUT || (ch >= CHAR_SPACE && ch <= CHAR_DEL) || ch == CHAR_BS ||
        ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_TAB)
      counted_items++;
  endtask

  // lets the engine go idle: every owed result in, then a few quiet cycles
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_DEFAULT_ATTR: print_attr = value;
      REG_ERASE_ATTR:   blank_attr = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stall before each beat
  initial begin : result_sink
    int stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && rst_ni));
    end
  end

  task automatic check_result();
    console_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with none owed: cursor %0d char %h attr %h scrolled %b",
               $time, res_ch.cursor_out, res_ch.cell_char, res_ch.cell_attr, res_ch.scrolled);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (res_ch.cursor_out !== want.cursor) begin
        $display("%0t: cursor_out expected %0d actual %0d", $time, want.cursor,
                 res_ch.cursor_out);
        error_count++;
      end
      if (res_ch.cell_char !== want.ch) begin
        $display("%0t: cell_char expected %h actual %h", $time, want.ch, res_ch.cell_char);
        error_count++;
      end
      if (res_ch.cell_attr !== want.attr) begin
        $display("%0t: cell_attr expected %h actual %h", $time, want.attr, res_ch.cell_attr);
        error_count++;
      end
      if (res_ch.scrolled !== want.scrolled) begin
        $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                 res_ch.scrolled);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) check_result();
  end

  // blank screen after reset, including a read past the last cell
  task automatic test_reset_contents();
    send_command(OP_READ, '0, '0);
    send_command(OP_READ, '1, '1);
  endtask

  task automatic test_control_characters();
    send_command(OP_PUT, "A", '0);
    send_command(OP_PUT, CHAR_BS, '0);
    send_command(OP_PUT, CHAR_BS, '1);      // already at column zero
    send_command(OP_PUT, CHAR_TAB, '0);
    send_command(OP_PUT, CHAR_CR, '0);
    send_command(OP_PUT, CHAR_LF, '0);
    send_command(OP_PUT, 8'h00, '0);        // unlisted control byte
    send_command(OP_PUT, 8'h80, '1);        // high half is ignored
    send_command(OP_PUT, 8'hff, '1);
    send_command(OP_PUT, CHAR_DEL, '0);     // top of the printable range
    send_command(OP_PUT, CHAR_SPACE, '0);
    send_command(OP_READ, '0, '0);
    send_command(OP_READ, '0, POS_W'(COLUMNS));
  endtask

  // last cell, scrolling by print, tab and linefeed
  task automatic test_screen_edge();
    send_command(OP_SET, '1, '1);
    send_command(OP_PUT, "Z", '0);
    send_command(OP_READ, '0, POS_W'(CELL_COUNT - 1 - COLUMNS));
    send_command(OP_READ, '0, POS_W'(CELL_COUNT - 1));
    send_command(OP_SET, '0, POS_W'(CELL_COUNT - 2));
    send_command(OP_PUT, CHAR_TAB, '0);
    send_command(OP_PUT, CHAR_LF, '0);
  endtask

  task automatic test_attributes_and_clear();
    logic [POS_W-1:0] spot;
    drain_results();
    write_register(REG_DEFAULT_ATTR, 8'hff);
    write_register(REG_ERASE_ATTR, 8'h00);
    write_register(CFG_IDX_W'(REG_ERASE_ATTR + 1), 8'h55);   // unmapped, no effect
    spot = POS_W'(cursor_model);
    send_command(OP_PUT, "x", '0);
    send_command(OP_READ, '0, spot);
    send_command(OP_CLEAR, '1, '1);
    send_command(OP_READ, '0, spot);
  endtask

  // one well-formed burst of console traffic, or a bit of noise
  task automatic random_session();
    int                kind;
    int                spot;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_command(op_e'(FUNC_W'($urandom_range(0, 3))), CHAR_W'($urandom_range(0, 255)),
                   POS_W'($urandom_range(0, POS_SPAN)));
    end else if (kind < 11) begin
      send_command(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, POS_SPAN)));
      repeat ($urandom_range(1, 3))
        send_command(OP_READ, CHAR_W'($urandom_range(0, 255)),
                     POS_W'($urandom_range(0, CELL_COUNT - 1)));
    end else if (kind < 75) begin
      // place the cursor, mostly on screen, sometimes on the bottom row or past the end
      case ($urandom_range(0, 9))
        0:       spot = $urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1);
        1:       spot = $urandom_range(CELL_COUNT, POS_SPAN);
        default: spot = $urandom_range(0, CELL_COUNT - 1);
      endcase
      send_command(OP_SET, CHAR_W'($urandom_range(0, 255)), POS_W'(spot));
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            case ($urandom_range(0, 3))
              0:       ch = CHAR_BS;
              1:       ch = CHAR_LF;
              2:       ch = CHAR_CR;
              default: ch = CHAR_TAB;
            endcase
          end
          2:       ch = CHAR_W'($urandom_range(0, 255));
          default: ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_DEL));
        endcase
        send_command(OP_PUT, ch, POS_W'($urandom_range(0, POS_SPAN)));
      end
      // read back around the cursor, across a scroll when one happened
      repeat ($urandom_range(1, 3)) begin
        spot = cursor_model - int'($urandom_range(0, 16));
        send_command(OP_READ, CHAR_W'($urandom_range(0, 255)), POS_W'((spot < 0) ? 0 : spot));
      end
    end else begin
      repeat ($urandom_range(1, 4))
        send_command(OP_READ, CHAR_W'($urandom_range(0, 255)),
                     POS_W'($urandom_range(0, POS_SPAN)));
    end
  endtask

  task automatic test_random_traffic();
    int chunk_end;
    counted_items = 0;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      drain_results();
      steady_flow = 1'b0;
      // first chunk takes the opposite extremes, later ones random attributes
      if (chunk == 0) begin
        write_register(REG_DEFAULT_ATTR, 8'h00);
        write_register(REG_ERASE_ATTR, 8'hff);
      end else begin
        write_register(REG_DEFAULT_ATTR, CFG_DATA_W'($urandom_range(0, 255)));
        write_register(REG_ERASE_ATTR, CFG_DATA_W'($urandom_range(0, 255)));
      end
      write_register(CFG_IDX_W'($urandom_range(REG_ERASE_ATTR + 1, TOP_REG_INDEX)),
                     CFG_DATA_W'($urandom_range(0, 255)));
      chunk_end = RANDOM_ITEMS * (chunk + 1) / RANDOM_CHUNKS;
      while (counted_items < chunk_end) begin
        steady_flow = ($urandom_range(0, 99) < 15);
        random_session();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.func      <= OP_PUT;
    cmd_ch.char_code <= '0;
    cmd_ch.position  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DEFAULT_ATTR;
    cfg_ch.data      <= '0;
    error_count   = 0;
    counted_items = 0;
    steady_flow   = 1'b0;
    print_attr    = ATTR_RESET;
    blank_attr    = ATTR_RESET;
    cursor_model  = 0;
    blank_cells(0, CELL_COUNT);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_control_characters();
    test_screen_edge();
    test_attributes_and_clear();
    test_random_traffic();
    drain_results();

    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
